// ===== src/sactm_pkg.sv =====
// Package for the cache directory model: sizes, state codes, payload structs,
// controller states and the control/status structs that join its two modules.
// No dependencies.
package sactm_pkg;

  localparam int NumSets        = 64;
  localparam int NumWays        = 8;
  localparam int LineBytes      = 64;
  localparam int AddrBits       = 48;
  localparam int MaxAccessBytes = 64;

  localparam int SetBits  = $clog2(NumSets);
  localparam int WayBits  = $clog2(NumWays);
  localparam int OffBits  = $clog2(LineBytes);
  localparam int LineBits = AddrBits - OffBits;
  localparam int AgeBits  = 16;
  localparam int CntBits  = 32;

  localparam logic [AgeBits-1:0] AgeMax = '1;

  typedef enum logic [1:0] {
    ST_INVALID   = 2'd0,
    ST_SHARED    = 2'd1,
    ST_EXCLUSIVE = 2'd2,
    ST_MODIFIED  = 2'd3
  } line_st_t;

  typedef enum logic [1:0] {
    REG_PREFETCH_ENABLE = 2'd0,
    REG_HIT_LATENCY     = 2'd1,
    REG_MISS_LATENCY    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [47:0] address;
    logic [6:0]  size_bytes;
    logic        write_req;
  } in_item_t;

  typedef struct packed {
    logic [10:0] latency;
    logic [1:0]  lines_touched;
    logic [1:0]  demand_hits;
    logic [2:0]  writebacks_now;
    logic [1:0]  prefetch_hits_now;
    logic [31:0] access_total;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] total_prefetch_hits;
    logic [31:0] total_writebacks;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_NEXT,
    S_DONE
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // take the input item, start a new access
    logic rd;       // read the set of the current lookup
    logic upd;      // compare, pick victim, write back the set
    logic adv;      // advance to the next lookup of the access
    logic publish;  // move the result to the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;     // current lookup is the last of the access
  } dp_stat_t;

endpackage

// ===== src/sactm_datapath.sv =====
// Datapath of the cache directory: set memories, lookup/replace logic,
// counters and result register. Depends on sactm_pkg.
module sactm_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  sactm_pkg::dp_cmd_t    cmd,
  output sactm_pkg::dp_stat_t   stat,
  input  sactm_pkg::in_item_t   in_item,
  input  logic                  pf_en,
  input  logic [3:0]            hit_lat,
  input  logic [9:0]            miss_lat,
  output sactm_pkg::out_item_t  res
);
  import sactm_pkg::*;

  localparam int RowTagW = NumWays * LineBits;
  localparam int RowAgeW = NumWays * AgeBits;

  // Set-wide rows; tags have no reset, state/age rows get a valid bit per set.
  logic [RowTagW-1:0] tag_mem [NumSets];
  logic [RowAgeW-1:0] age_mem [NumSets];
  logic [NumWays*2-1:0] st_mem [NumSets];
  logic [NumSets-1:0] set_valid;

  logic [LineBits-1:0] base_line;
  logic                wr;
  logic                two_lines;
  logic                line_k;   // demand line index
  logic                is_pf;    // current lookup is a prefetch

  logic [RowTagW-1:0]   tag_row;
  logic [RowAgeW-1:0]   age_raw;
  logic [NumWays*2-1:0] st_raw;
  logic                 row_valid;
  logic [SetBits-1:0]   rd_set;

  logic [10:0] lat;
  logic [1:0]  dhits, phits;
  logic [2:0]  wbs;
  logic [CntBits-1:0] c_acc, c_hit, c_miss, c_pfh, c_wb;

  logic [LineBits-1:0] cur_line;
  logic [SetBits-1:0]  cur_set;
  logic [OffBits:0]    span;

  assign cur_line = base_line + LineBits'(line_k) + LineBits'(is_pf);
  assign cur_set  = cur_line[SetBits-1:0];
  assign stat.last = is_pf ? (!two_lines || line_k) : (!pf_en && (!two_lines || line_k));

  assign span = {1'b0, in_item.address[OffBits-1:0]} +
                ((in_item.size_bytes == '0) ? (OffBits+1)'(1) :
                 (in_item.size_bytes > 7'(MaxAccessBytes)) ? (OffBits+1)'(MaxAccessBytes) :
                 (OffBits+1)'(in_item.size_bytes)) - (OffBits+1)'(1);

  // Registered read of the current set.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      tag_row <= tag_mem[cur_set];
      age_raw <= age_mem[cur_set];
      st_raw  <= st_mem[cur_set];
      rd_set  <= cur_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (cmd.rd) begin
      row_valid <= set_valid[cur_set];
    end
  end

  // Lookup and replacement on the read row.
  logic [NumWays-1:0]  hitv;
  logic                hit;
  logic [WayBits-1:0]  hit_way, inv_way, old_way, victim;
  logic                any_inv;
  logic [AgeBits-1:0]  oldest;
  logic [NumWays*2-1:0] st_row, st_new;
  logic [RowAgeW-1:0]  age_row, age_new;
  logic [RowTagW-1:0]  tag_new;
  logic [WayBits-1:0]  keep;
  logic                wb_now;

  assign st_row  = row_valid ? st_raw : '0;
  assign age_row = row_valid ? age_raw : '0;

  always_comb begin
    hit = 1'b0; hit_way = '0; any_inv = 1'b0; inv_way = '0;
    old_way = '0; oldest = age_row[AgeBits-1:0];
    for (int w = 0; w < NumWays; w++) begin
      hitv[w] = (st_row[2*w +: 2] != ST_INVALID) &&
                (tag_row[w*LineBits +: LineBits] == cur_line);
      if (hitv[w] && !hit) begin
        hit = 1'b1; hit_way = WayBits'(w);
      end
      if (st_row[2*w +: 2] == ST_INVALID && !any_inv) begin
        any_inv = 1'b1; inv_way = WayBits'(w);
      end
      if (age_row[w*AgeBits +: AgeBits] > oldest) begin
        oldest = age_row[w*AgeBits +: AgeBits]; old_way = WayBits'(w);
      end
    end
    victim = any_inv ? inv_way : old_way;
    keep   = hit ? hit_way : victim;
    wb_now = !hit && (st_row[2*victim +: 2] == ST_MODIFIED);
    st_new = st_row; tag_new = tag_row;
    for (int w = 0; w < NumWays; w++) begin
      if (WayBits'(w) == keep) begin
        age_new[w*AgeBits +: AgeBits] = '0;
      end else if (age_row[w*AgeBits +: AgeBits] != AgeMax) begin
        age_new[w*AgeBits +: AgeBits] = age_row[w*AgeBits +: AgeBits] + AgeBits'(1);
      end else begin
        age_new[w*AgeBits +: AgeBits] = AgeMax;
      end
    end
    if (hit) begin
      if (wr && !is_pf && st_row[2*hit_way +: 2] != ST_MODIFIED) begin
        st_new[2*hit_way +: 2] = ST_MODIFIED;
      end
    end else begin
      st_new[2*victim +: 2] = (wr && !is_pf) ? ST_MODIFIED : ST_EXCLUSIVE;
      tag_new[victim*LineBits +: LineBits] = cur_line;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      tag_mem[rd_set] <= tag_new;
      age_mem[rd_set] <= age_new;
      st_mem[rd_set]  <= st_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_valid <= '0;
      c_acc <= '0; c_hit <= '0; c_miss <= '0; c_pfh <= '0; c_wb <= '0;
      line_k <= 1'b0; is_pf <= 1'b0;
    end else begin
      if (cmd.load) begin
        c_acc  <= c_acc + 1'b1;
        line_k <= 1'b0;
        is_pf  <= 1'b0;
      end
      if (cmd.upd) begin
        set_valid[rd_set] <= 1'b1;
        if (hit) c_hit <= c_hit + 1'b1;
        else c_miss <= c_miss + 1'b1;
        if (hit && is_pf) c_pfh <= c_pfh + 1'b1;
        if (wb_now) c_wb <= c_wb + 1'b1;
      end
      if (cmd.adv) begin
        // demand -> its prefetch (if enabled), else next demand line
        if (!is_pf && pf_en) begin
          is_pf <= 1'b1;
        end else begin
          is_pf  <= 1'b0;
          line_k <= 1'b1;
        end
      end
    end
  end

  // Per-access counts.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_line <= in_item.address[AddrBits-1:OffBits];
      wr        <= in_item.write_req;
      two_lines <= span[OffBits];
      lat <= '0; dhits <= '0; phits <= '0; wbs <= '0;
    end else if (cmd.upd) begin
      if (!is_pf) begin
        lat <= lat + (hit ? 11'(hit_lat) : 11'(miss_lat));
        if (hit) dhits <= dhits + 1'b1;
      end else if (hit) begin
        phits <= phits + 1'b1;
      end
      if (wb_now) wbs <= wbs + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res.latency             <= lat;
      res.lines_touched       <= two_lines ? 2'd2 : 2'd1;
      res.demand_hits         <= dhits;
      res.writebacks_now      <= wbs;
      res.prefetch_hits_now   <= phits;
      res.access_total        <= c_acc;
      res.hit_total           <= c_hit;
      res.miss_total          <= c_miss;
      res.total_prefetch_hits <= c_pfh;
      res.total_writebacks    <= c_wb;
    end
  end

endmodule

// ===== src/sactm_ctrl.sv =====
// Controller of the cache directory: sequences read/update per lookup and
// the input/output handshakes. Depends on sactm_pkg.
module sactm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output sactm_pkg::dp_cmd_t  cmd,
  input  sactm_pkg::dp_stat_t stat
);
  import sactm_pkg::*;

  ctl_state_t state, state_next;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_READ;
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: state_next = stat.last ? S_DONE : S_NEXT;
      S_NEXT:   state_next = S_READ;
      S_DONE:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_READ:   cmd.rd = 1'b1;
      S_UPDATE: begin
        cmd.upd = 1'b1;
        cmd.adv = !stat.last;
      end
      S_NEXT:   ;
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.publish = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load outside idle");
  a_upd_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> $past(cmd.rd)) else $error("update without read");
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || !out_stall)) else $error("result overwritten");

endmodule

// ===== src/set_assoc_cache_tag_model_unit.sv =====
// Top level of the cache directory model: config registers, controller and
// datapath. Depends on sactm_pkg, sactm_ctrl, sactm_datapath.
//
// A 64-set, 8-way cache directory with age LRU and optional next-line
// prefetch. Each accepted access performs one lookup per demand line (one or
// two) and, with prefetch on, one prefetch lookup after each, for one to four
// lookups. Every lookup is a read-modify-write of one set row in the set
// memories in a read state and an update state, with an advance state
// between consecutive lookups; an access runs from the accept state through
// its lookups to the result state. The next access is accepted once the
// result has moved into the output register, which
// holds it while the consumer stalls. No clearing pass is needed after reset:
// per-set valid bits make untouched sets read as invalid with zero ages.
// Write configuration registers only while the block is idle.
module set_assoc_cache_tag_model_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sactm_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sactm_pkg::out_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import sactm_pkg::*;

  logic       pf_en;
  logic [3:0] hit_lat;
  logic [9:0] miss_lat;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  // Config writes always complete; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pf_en    <= 1'b1;
      hit_lat  <= 4'd1;
      miss_lat <= 10'd10;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_PREFETCH_ENABLE: pf_en    <= cfg_data[0];
        REG_HIT_LATENCY:     hit_lat  <= cfg_data[3:0];
        REG_MISS_LATENCY:    miss_lat <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  sactm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  sactm_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .in_item (in_data),
    .pf_en, .hit_lat, .miss_lat,
    .res     (out_data)
  );

endmodule

// ===== sim/set_assoc_cache_tag_model_unit_tb.sv =====
// Testbench for the cache directory model: a directed table of accesses and
// then random traffic, each transfer scored against a behavioral directory.
// Depends on sactm_pkg and set_assoc_cache_tag_model_unit.
`timescale 1ns / 1ps

module set_assoc_cache_tag_model_unit_tb;
  import sactm_pkg::*;

  localparam int RandItems = 1200;
  localparam int IdleLimit = 20000;
  localparam int DirRows   = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  set_assoc_cache_tag_model_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the directory and its settings.
  logic [LineBits-1:0] shd_tag [NumSets][NumWays];
  line_st_t            shd_st  [NumSets][NumWays];
  logic [AgeBits-1:0]  shd_age [NumSets][NumWays];
  logic [31:0] n_acc, n_hit, n_miss, n_pfh, n_wb;
  logic        pf_on;
  logic [3:0]  lat_hit;
  logic [9:0]  lat_miss;
  int          wb_acc;

  out_item_t expected_results[$];
  logic      check_mask[$];   // 1: compare only what a table row typed in
  out_item_t typed_results[$];
  int errors = 0;
  int results_seen = 0;
  int accepted_in = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit stall_rand = 1'b1;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    errors++;
    $display("mismatch @%0t result %0d %s: got %0h expected %0h",
             $realtime, results_seen, what, got, exp);
  endtask

  // Age every way but the one kept, saturating.
  function automatic void age_set(input int s, input int keep);
    for (int w = 0; w < NumWays; w++) begin
      if (w == keep) shd_age[s][w] = '0;
      else if (shd_age[s][w] != AgeMax) shd_age[s][w]++;
    end
  endfunction

  function automatic bit dir_lookup(input logic [LineBits-1:0] ln, input bit wr);
    int s, victim;
    logic [AgeBits-1:0] oldest;
    s = int'(ln % NumSets);
    for (int w = 0; w < NumWays; w++) begin
      if (shd_st[s][w] != ST_INVALID && shd_tag[s][w] == ln) begin
        age_set(s, w);
        n_hit++;
        if (wr && (shd_st[s][w] == ST_SHARED || shd_st[s][w] == ST_EXCLUSIVE))
          shd_st[s][w] = ST_MODIFIED;
        return 1'b1;
      end
    end
    n_miss++;
    victim = -1;
    for (int w = 0; w < NumWays; w++)
      if (victim < 0 && shd_st[s][w] == ST_INVALID) victim = w;
    if (victim < 0) begin
      victim = 0;
      oldest = shd_age[s][0];
      for (int w = 1; w < NumWays; w++)
        if (shd_age[s][w] > oldest) begin
          oldest = shd_age[s][w];
          victim = w;
        end
    end
    if (shd_st[s][victim] == ST_MODIFIED) begin
      n_wb++;
      wb_acc++;
    end
    shd_tag[s][victim] = ln;
    shd_st[s][victim] = wr ? ST_MODIFIED : ST_EXCLUSIVE;
    age_set(s, victim);
    return 1'b0;
  endfunction

  function automatic out_item_t predict_access(input in_item_t it);
    out_item_t r;
    int sz, off, nl, lat, dh, ph;
    logic [LineBits-1:0] ln;
    sz = it.size_bytes;
    if (sz == 0) sz = 1;
    if (sz > MaxAccessBytes) sz = MaxAccessBytes;
    n_acc++;
    wb_acc = 0;
    off = it.address[OffBits-1:0];
    nl = (off + sz - 1) / LineBytes + 1;
    lat = 0; dh = 0; ph = 0;
    ln = it.address[AddrBits-1:OffBits];
    for (int k = 0; k < nl; k++) begin
      if (dir_lookup(ln, it.write_req)) begin
        dh++;
        lat += lat_hit;
      end else lat += lat_miss;
      if (pf_on && dir_lookup(ln + 1'b1, 1'b0)) begin
        n_pfh++;
        ph++;
      end
      ln = ln + 1'b1;   // wraps at the top of memory
    end
    r.latency = (lat > 2047) ? 11'd2047 : lat[10:0];
    r.lines_touched = nl[1:0];
    r.demand_hits = dh[1:0];
    r.writebacks_now = (wb_acc > 7) ? 3'd7 : wb_acc[2:0];
    r.prefetch_hits_now = ph[1:0];
    r.access_total = n_acc;
    r.hit_total = n_hit;
    r.miss_total = n_miss;
    r.total_prefetch_hits = n_pfh;
    r.total_writebacks = n_wb;
    return r;
  endfunction

  // Directed rows; typed rows carry the few values obvious at a glance.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } dir_row_t;
  dir_row_t dir_rows[DirRows];

  function automatic dir_row_t mk(input logic [47:0] a, input logic [6:0] sz, input bit wr);
    dir_row_t d;
    d.item = '{address: a, size_bytes: sz, write_req: wr};
    d.typed = 1'b0;
    d.res = '0;
    return d;
  endfunction

  initial begin
    dir_rows[0]  = mk(48'h0, 7'd1, 1'b0);
    // First access after reset: cold miss plus cold prefetch miss.
    dir_rows[0].typed = 1'b1;
    dir_rows[0].res = '{latency: 11'd10, lines_touched: 2'd1, demand_hits: 2'd0,
                        writebacks_now: 3'd0, prefetch_hits_now: 2'd0,
                        access_total: 32'd1, hit_total: 32'd0,
                        miss_total: 32'd2, total_prefetch_hits: 32'd0,
                        total_writebacks: 32'd0};
    dir_rows[1]  = mk(48'h40, 7'd1, 1'b0);          // prefetched line hits
    dir_rows[2]  = mk(48'h3f, 7'd2, 1'b1);          // spans two lines, write
    dir_rows[3]  = mk(48'hffff_ffff_ffff, 7'd64, 1'b1); // top of memory, wraps
    dir_rows[4]  = mk(48'h1000, 7'd0, 1'b0);        // zero length
    dir_rows[5]  = mk(48'h2001, 7'd127, 1'b1);      // overlong, clipped
    dir_rows[6]  = mk(48'h2000, 7'd64, 1'b0);
    dir_rows[7]  = mk(48'h0, 7'd1, 1'b1);           // write hit on a dirty line
    for (int i = 8; i < DirRows; i++)               // same set, forces evictions
      dir_rows[i] = mk(48'(i) << 12, 7'd64, 1'b1);
  end

  // Receiver: random stall pattern, with one long hold-off.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else if (stall_rand) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= 1'b0;
  end

  // Score every result transfer.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      out_item_t e, t;
      bit only_typed;
      if (expected_results.size() == 0) begin
        errors++;
        $display("unexpected result @%0t", $realtime);
      end else begin
        e = expected_results.pop_front();
        only_typed = check_mask.pop_front();
        t = typed_results.pop_front();
        if (only_typed) e = t;
        if (out_data.latency !== e.latency) report("latency", out_data.latency, e.latency);
        if (out_data.lines_touched !== e.lines_touched)
          report("lines_touched", out_data.lines_touched, e.lines_touched);
        if (out_data.demand_hits !== e.demand_hits)
          report("demand_hits", out_data.demand_hits, e.demand_hits);
        if (out_data.writebacks_now !== e.writebacks_now)
          report("writebacks_now", out_data.writebacks_now, e.writebacks_now);
        if (out_data.prefetch_hits_now !== e.prefetch_hits_now)
          report("prefetch_hits_now", out_data.prefetch_hits_now, e.prefetch_hits_now);
        if (out_data.access_total !== e.access_total)
          report("access_total", out_data.access_total, e.access_total);
        if (out_data.hit_total !== e.hit_total)
          report("hit_total", out_data.hit_total, e.hit_total);
        if (out_data.miss_total !== e.miss_total)
          report("miss_total", out_data.miss_total, e.miss_total);
        if (out_data.total_prefetch_hits !== e.total_prefetch_hits)
          report("total_prefetch_hits", out_data.total_prefetch_hits, e.total_prefetch_hits);
        if (out_data.total_writebacks !== e.total_writebacks)
          report("total_writebacks", out_data.total_writebacks, e.total_writebacks);
      end
      results_seen++;
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one access; hold it until the transfer and queue its prediction.
  task automatic send_access(input in_item_t it, input bit typed, input out_item_t res);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    accepted_in++;
    expected_results.push_back(predict_access(it));
    check_mask.push_back(typed);
    typed_results.push_back(res);
  endtask

  // Send one access of a burst; valid is dropped only between bursts, never inside one.
  task automatic send_burst(input in_item_t it);
    send_access(it, 1'b0, '0);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PREFETCH_ENABLE: pf_on = val[0];
      REG_HIT_LATENCY:     lat_hit = val[3:0];
      REG_MISS_LATENCY:    lat_miss = val[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait for every expected result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t rand_access();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 9);
    it.write_req = 1'($urandom_range(0, 1));
    it.size_bytes = (pick == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 64));
    if (pick < 7)      // hot region: 64 tags per set, well over the ways
      it.address = {30'd0, 4'($urandom()), 6'($urandom()), 6'($urandom()), 2'd0}
                   | 48'($urandom_range(0, 3));
    else if (pick < 9) // near the top of memory
      it.address = 48'hffff_ffff_0000 | 48'($urandom_range(0, 16'hffff));
    else
      it.address = {$urandom(), 16'($urandom())};
    return it;
  endfunction

  initial begin
    int burst;
    int gap;
    for (int s = 0; s < NumSets; s++)
      for (int w = 0; w < NumWays; w++) begin
        shd_tag[s][w] = '0;
        shd_st[s][w] = ST_INVALID;
        shd_age[s][w] = '0;
      end
    n_acc = 0; n_hit = 0; n_miss = 0; n_pfh = 0; n_wb = 0;
    pf_on = 1'b1; lat_hit = 4'd1; lat_miss = 10'd10;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, reset settings.
    for (int i = 0; i < DirRows; i++)
      send_access(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // Extremes of the settings.
    cfg_write(REG_HIT_LATENCY, 32'd15);
    cfg_write(REG_MISS_LATENCY, 32'd1023);
    cfg_write(REG_PREFETCH_ENABLE, 32'd0);
    send_access('{address: 48'h7f, size_bytes: 7'd64, write_req: 1'b0}, 1'b0, '0);
    send_access('{address: 48'h5_0000, size_bytes: 7'd2, write_req: 1'b1}, 1'b0, '0);
    drain();
    cfg_write(REG_HIT_LATENCY, 32'd0);
    cfg_write(REG_MISS_LATENCY, 32'd0);
    cfg_write(REG_PREFETCH_ENABLE, 32'd1);
    send_access('{address: 48'h7f, size_bytes: 7'd64, write_req: 1'b0}, 1'b0, '0);
    drain();

    // Pressure: receiver holds off while the sender keeps offering.
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_burst(rand_access());
    join
    drain();

    // Random phases with varied settings; bursts with gaps, except in phase 1.
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(REG_PREFETCH_ENABLE, 32'($urandom_range(0, 1)));
      cfg_write(REG_HIT_LATENCY, 32'($urandom_range(0, 15)));
      cfg_write(REG_MISS_LATENCY, 32'($urandom_range(0, 1023)));
      stall_rand = (ph != 2);
      for (int n = 0; n < RandItems / 4; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++) begin
          send_burst(rand_access());
          n++;
        end
        gap = (ph == 1) ? 0 : int'($urandom_range(0, 6));
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      drain();
    end

    $display("Covered %0d accesses and %0d results over directed, pressure and",
             accepted_in, results_seen);
    $display("four random phases with prefetch and latency settings varied.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
